// File: src/midi_output_coalescing_queue_top_defines.svh
// assertion macros for the midi output coalescing queue
`ifndef MIDI_OUTPUT_COALESCING_QUEUE_TOP_DEFINES_SVH
`define MIDI_OUTPUT_COALESCING_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MOCQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mocq assertion failed");
`define MOCQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `MOCQ_ASSERT(lbl, clk, rstn, !(cond))
`else
`define MOCQ_ASSERT(lbl, clk, rstn, prop)
`define MOCQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: src/mocq_pkg.sv
// shared constants for the midi output coalescing queue
package mocq_pkg;

  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int CHANNELS        = 16;
  localparam int SLOTS           = 2 * CHANNELS;
  localparam int SLOT_W          = $clog2(SLOTS);
  localparam int ENTRY_W         = 26;

  localparam logic [7:0] FLUSH_RESET = 8'd16;

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_COALESCED = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_EMITTED   = 3'd4;
  localparam logic [2:0] ST_NOTHING   = 3'd5;

  localparam logic [3:0] NIB_BEND = 4'hE;
  localparam logic [3:0] NIB_CC   = 4'hB;
  localparam logic [6:0] CC_MOD   = 7'd1;
  localparam logic [2:0] LEN_FULL = 3'd3;

endpackage

// File: src/midi_output_coalescing_queue_top.sv
// midi output coalescing queue: fifo, per-channel coalescing and flush sequencer
//
// channel | direction | beat contents
// in_     | slave     | tuser kind, tdata msg_len/status/data bytes
// out_    | master    | tdata status/len/bytes/high water/counters, tlast
// cfg_    | write     | flush_interval
//
// a submit passes idle then exec; a step adds pop when it pops, and may run the flush scan
// the first result is registered in exec, or in pop after the fifo ram read
// the flush scan walks up to 32 bend/cc1 slots, one a cycle, holding on a pending one
// one result register; the sequencer holds while it is full and out_tready is low
// rst_n clears control state; fifo entries are undefined until written
`include "midi_output_coalescing_queue_top_defines.svh"

module midi_output_coalescing_queue_top #(
  parameter int QUEUE_DEPTH = mocq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [2:0] msg_len, [10:3] status_byte, [18:11] data_byte_one, [26:19] data_byte_two
  input  logic [31:0]  in_tdata,
  // [0] kind
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [4:3] out_len, [12:5] out_byte_zero, [20:13] out_byte_one,
  // [28:21] out_byte_two, [37:29] queue_high_water, [69:38] drops_total,
  // [101:70] bend_merges, [133:102] mod_merges
  output logic [135:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_wr_en,
  input  logic [7:0]   cfg_wr_data
);

  import mocq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  localparam logic [1:0] INC_DROP = 2'd0;
  localparam logic [1:0] INC_BEND = 2'd1;
  localparam logic [1:0] INC_MOD  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                kind_r;
  logic [2:0]          len_r;
  logic [7:0]          sb_r, d1_r, d2_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       hw_r, hw_nxt;
  logic [CHANNELS-1:0] bend_pend_r, bend_pend_nxt;
  logic [CHANNELS-1:0] mod_pend_r, mod_pend_nxt;
  logic [13:0]         bend_val_r [CHANNELS];
  logic [6:0]          mod_val_r [CHANNELS];
  logic [7:0]          sent_r, sent_nxt;
  logic [7:0]          flush_int_r;
  logic [31:0]         drops_r, bmerge_r, mmerge_r;
  logic [SLOT_W-1:0]   idx_r, idx_nxt;

  logic                out_valid_r;
  logic [2:0]          o_status_r;
  logic [1:0]          o_len_r;
  logic [7:0]          o_b0_r, o_b1_r, o_b2_r;
  logic                o_last_r;

  logic                out_free;
  logic                emit;
  logic [2:0]          e_status;
  logic [1:0]          e_len;
  logic [7:0]          e_b0, e_b1, e_b2;
  logic                e_last;

  logic                inc_en;
  logic [1:0]          inc_sel;
  logic [31:0]         inc_src, inc_sum;

  logic [3:0]          ch;
  logic                is_bend, is_mod, full;
  logic [1:0]          clip_len;
  logic [ENTRY_W-1:0]  wr_entry, rd_entry;
  logic [AW:0]         tail_sum;
  logic [AW-1:0]       tail;
  logic                ram_wr_en, ram_rd_en;
  logic                bend_wr, mod_wr;

  logic [SLOTS-1:0]    pend_vec, rest_vec;
  logic                any_pend, slot_pend, slot_last;
  logic [3:0]          slot_ch;
  logic [7:0]          sent_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {2'b00, mmerge_r, bmerge_r, drops_r, 9'(hw_r),
                       o_b2_r, o_b1_r, o_b0_r, o_len_r, o_status_r};

  // item decode
  assign ch       = sb_r[3:0];
  assign is_bend  = (len_r == LEN_FULL) && (sb_r[7:4] == NIB_BEND);
  assign is_mod   = (len_r == LEN_FULL) && (sb_r[7:4] == NIB_CC) && (d1_r[6:0] == CC_MOD);
  assign clip_len = (len_r > LEN_FULL) ? 2'd3 : len_r[1:0];
  assign full     = (count_r >= CW'(QUEUE_DEPTH));
  assign wr_entry = {(clip_len == 2'd3) ? d2_r : 8'd0,
                     (clip_len >= 2'd2) ? d1_r : 8'd0,
                     sb_r, clip_len};
  assign tail_sum = (AW+1)'(head_r) + (AW+1)'(count_r[AW-1:0]);
  assign tail     = (tail_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];

  // pending slots: even slot pitch bend, odd slot cc1
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      pend_vec[2*c]   = bend_pend_r[c];
      pend_vec[2*c+1] = mod_pend_r[c];
    end
  end
  assign any_pend  = |pend_vec;
  assign slot_pend = pend_vec[idx_r];
  assign rest_vec  = (pend_vec >> idx_r) >> 1;
  assign slot_last = ~|rest_vec;
  assign slot_ch   = idx_r[SLOT_W-1:1];
  assign sent_inc  = sent_r + 8'd1;

  // shared counter incrementer
  always_comb begin
    case (inc_sel)
      INC_DROP: inc_src = drops_r;
      INC_BEND: inc_src = bmerge_r;
      INC_MOD:  inc_src = mmerge_r;
      default:  inc_src = drops_r;
    endcase
  end
  assign inc_sum = inc_src + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    hw_nxt        = hw_r;
    bend_pend_nxt = bend_pend_r;
    mod_pend_nxt  = mod_pend_r;
    sent_nxt      = sent_r;
    idx_nxt       = idx_r;
    emit          = 1'b0;
    e_status      = ST_NOTHING;
    e_len         = 2'd0;
    e_b0          = 8'd0;
    e_b1          = 8'd0;
    e_b2          = 8'd0;
    e_last        = 1'b1;
    inc_en        = 1'b0;
    inc_sel       = INC_DROP;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    bend_wr       = 1'b0;
    mod_wr        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!kind_r) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
            if (len_r == 3'd0) begin
              e_status = ST_EMPTY;
            end else if (is_bend) begin
              e_status           = ST_COALESCED;
              bend_wr            = 1'b1;
              bend_pend_nxt[ch]  = 1'b1;
              inc_sel            = INC_BEND;
              inc_en             = bend_pend_r[ch];
            end else if (is_mod) begin
              e_status           = ST_COALESCED;
              mod_wr             = 1'b1;
              mod_pend_nxt[ch]   = 1'b1;
              inc_sel            = INC_MOD;
              inc_en             = mod_pend_r[ch];
            end else if (full) begin
              e_status = ST_DROPPED;
              inc_sel  = INC_DROP;
              inc_en   = 1'b1;
            end else begin
              e_status  = ST_QUEUED;
              ram_wr_en = 1'b1;
              count_nxt = count_r + CW'(1);
              if (count_nxt > hw_r) begin
                hw_nxt = count_nxt;
              end
            end
          end
        end else if (count_r != '0) begin
          ram_rd_en = 1'b1;
          state_nxt = S_POP;
        end else if (any_pend) begin
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end else if (out_free) begin
          emit      = 1'b1;
          e_status  = ST_NOTHING;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          emit      = 1'b1;
          e_status  = ST_EMITTED;
          e_len     = rd_entry[1:0];
          e_b0      = rd_entry[9:2];
          e_b1      = rd_entry[17:10];
          e_b2      = rd_entry[25:18];
          count_nxt = count_r - CW'(1);
          head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
          sent_nxt  = sent_inc;
          state_nxt = S_IDLE;
          if (sent_inc >= flush_int_r) begin
            sent_nxt = 8'd0;
            if (any_pend) begin
              e_last    = 1'b0;
              idx_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (!slot_pend) begin
          idx_nxt = idx_r + SLOT_W'(1);
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = S_IDLE;
          end
        end else if (out_free) begin
          emit     = 1'b1;
          e_status = ST_EMITTED;
          e_len    = 2'd3;
          e_last   = slot_last;
          if (!idx_r[0]) begin
            e_b0                   = {NIB_BEND, slot_ch};
            e_b1                   = {1'b0, bend_val_r[slot_ch][6:0]};
            e_b2                   = {1'b0, bend_val_r[slot_ch][13:7]};
            bend_pend_nxt[slot_ch] = 1'b0;
          end else begin
            e_b0                  = {NIB_CC, slot_ch};
            e_b1                  = {1'b0, CC_MOD};
            e_b2                  = {1'b0, mod_val_r[slot_ch]};
            mod_pend_nxt[slot_ch] = 1'b0;
          end
          idx_nxt = idx_r + SLOT_W'(1);
          if (slot_last || idx_r == SLOT_W'(SLOTS - 1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  mocq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail),
    .wr_data (wr_entry),
    .rd_en   (ram_rd_en),
    .rd_addr (head_r),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      hw_r        <= '0;
      bend_pend_r <= '0;
      mod_pend_r  <= '0;
      sent_r      <= 8'd0;
      flush_int_r <= FLUSH_RESET;
      drops_r     <= 32'd0;
      bmerge_r    <= 32'd0;
      mmerge_r    <= 32'd0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        bend_val_r[c] <= 14'd0;
        mod_val_r[c]  <= 7'd0;
      end
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      hw_r        <= hw_nxt;
      bend_pend_r <= bend_pend_nxt;
      mod_pend_r  <= mod_pend_nxt;
      sent_r      <= sent_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr_en) begin
        flush_int_r <= cfg_wr_data;
      end
      if (inc_en) begin
        case (inc_sel)
          INC_DROP: drops_r  <= inc_sum;
          INC_BEND: bmerge_r <= inc_sum;
          INC_MOD:  mmerge_r <= inc_sum;
          default:  drops_r  <= drops_r;
        endcase
      end
      if (bend_wr) begin
        bend_val_r[ch] <= {d2_r[6:0], d1_r[6:0]};
      end
      if (mod_wr) begin
        mod_val_r[ch] <= d2_r[6:0];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // beat capture and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= in_tuser[0];
      len_r  <= in_tdata[2:0];
      sb_r   <= in_tdata[10:3];
      d1_r   <= in_tdata[18:11];
      d2_r   <= in_tdata[26:19];
    end
    if (emit) begin
      o_status_r <= e_status;
      o_len_r    <= e_len;
      o_b0_r     <= e_b0;
      o_b1_r     <= e_b1;
      o_b2_r     <= e_b2;
      o_last_r   <= e_last;
    end
  end

  `MOCQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(QUEUE_DEPTH))
  `MOCQ_ASSERT(a_hw_covers, clk, rst_n, hw_r >= count_r)
  `MOCQ_ASSERT_NEVER(a_pop_empty, clk, rst_n, ram_rd_en && (count_r == '0))
  `MOCQ_ASSERT(a_flush_clears, clk, rst_n,
    (state_r == S_SCAN && emit && e_last) |=> (pend_vec == '0))
  `MOCQ_ASSERT_NEVER(a_emit_overrun, clk, rst_n, emit && out_valid_r && !out_tready)

endmodule

// File: src/mocq_ram.sv
// generic single-write, single-read ram with registered read data
module mocq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
